>>> rtl/core/bdpc_pkg.sv
// package: register indexes, reset values and the result word type of the button classifier
`default_nettype none

package bdpc_pkg;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE  = 2'd0,
    REG_SHORT_MAX = 2'd1,
    REG_LONG      = 2'd2
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd15;
  localparam logic [CFG_W-1:0] SHORT_MAX_RST = 16'd1000;
  localparam logic [CFG_W-1:0] LONG_RST      = 16'd3000;

  typedef struct packed {
    logic press;
    logic shrt;
    logic lng;
    logic rel;
    logic level;
  } evt_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce;
    logic [CFG_W-1:0] short_max;
    logic [CFG_W-1:0] long_lim;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/bdpc_step.sv
// combinational next-state and event logic for one tick of the button classifier
`default_nettype none

module bdpc_step
  import bdpc_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire  logic                   pin,
  input  wire  cfg_t                   cfg,
  input  wire  logic                   raw_seen,
  input  wire  logic                   settling,
  input  wire  logic [TIMER_WIDTH-1:0] settle_cnt,
  input  wire  logic                   debounced,
  input  wire  logic                   hold_armed,
  input  wire  logic [TIMER_WIDTH-1:0] hold_cnt,
  output logic                         raw_seen_nxt,
  output logic                         settling_nxt,
  output logic [TIMER_WIDTH-1:0]       settle_cnt_nxt,
  output logic                         debounced_nxt,
  output logic                         hold_armed_nxt,
  output logic [TIMER_WIDTH-1:0]       hold_cnt_nxt,
  output evt_t                         evt
);

  // compare width covers both the timers and the 16-bit registers
  localparam int unsigned CW = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

  logic [TIMER_WIDTH-1:0] hold_inc;
  logic [TIMER_WIDTH-1:0] settle_inc;
  logic [CW-1:0]          settle_ext;
  logic [CW-1:0]          hold_ext;
  logic [CW-1:0]          deb_ext;
  logic [CW-1:0]          short_ext;
  logic [CW-1:0]          long_ext;
  logic                   take;
  logic                   edge_seen;

  assign hold_inc   = (&hold_cnt) ? hold_cnt : hold_cnt + 1'b1;
  assign settle_inc = (&settle_cnt) ? settle_cnt : settle_cnt + 1'b1;
  assign deb_ext    = CW'(cfg.debounce);
  assign short_ext  = CW'(cfg.short_max);
  assign long_ext   = CW'(cfg.long_lim);
  assign hold_ext   = CW'(hold_inc);

  always_comb begin
    raw_seen_nxt   = raw_seen;
    settling_nxt   = settling;
    settle_cnt_nxt = settle_cnt;
    debounced_nxt  = debounced;
    hold_armed_nxt = hold_armed;
    hold_cnt_nxt   = hold_inc;
    evt            = '0;

    if (pin != raw_seen) begin
      raw_seen_nxt   = pin;
      settling_nxt   = 1'b1;
      settle_cnt_nxt = '0;
    end else if (settling) begin
      settle_cnt_nxt = settle_inc;
    end

    settle_ext = CW'(settle_cnt_nxt);
    take       = settling_nxt && (settle_ext >= deb_ext);
    if (take) begin
      debounced_nxt = raw_seen_nxt;
      settling_nxt  = 1'b0;
    end

    edge_seen = take && (raw_seen_nxt != debounced);
    if (edge_seen) begin
      if (!raw_seen_nxt) begin
        hold_armed_nxt = 1'b1;
        hold_cnt_nxt   = '0;
        evt.press      = 1'b1;
      end else begin
        evt.shrt       = (hold_ext <= short_ext);
        evt.rel        = 1'b1;
        hold_armed_nxt = 1'b0;
      end
    end

    // long test sees the count after a possible restart on press
    if (hold_armed_nxt && (CW'(hold_cnt_nxt) >= long_ext)) begin
      evt.lng        = 1'b1;
      hold_armed_nxt = 1'b0;
    end

    evt.level = debounced_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/core/button_debounce_press_classifier_core.sv
// Active-low push button debouncer with press, release, short and long press events.
// One in_ word carries one pin sample, taken once per tick strobe (e.g. 1 ms).
// Each accepted in_ word gives exactly one out_ word: four event flags and the
// debounced level after that tick.
// Path: an accepted sample is held in the input register, the step logic runs
// on it, and the out_ word is registered in the result register; a stalled
// receiver can keep the sample waiting in the input register in between.
// Throughput: one word per cycle while the receiver takes each word, as the
// step logic between the input register and the result register is combinational.
// If the receiver stalls, the result register holds its word and the input
// register still takes one more word; in_ready drops only when both are full.
// cfg_ writes (index 0 debounce, 1 short limit, 2 long limit, 16-bit data) are
// taken in any cycle with cfg_ready always high; other indexes are ignored.
// Synchronous reset (rst_n low) restores register defaults 15, 1000 and 3000,
// sets the debounced level to released, clears all timers and drops both
// valid flags. Timers are TIMER_WIDTH bits and saturate at all ones.
`default_nettype none

module button_debounce_press_classifier_core
  import bdpc_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire  logic                 clk,
  input  wire  logic                 rst_n,
  input  wire  logic                 in_valid,
  output logic                       in_ready,
  input  wire  logic                 in_pin_level,
  output logic                       out_valid,
  input  wire  logic                 out_ready,
  output logic                       out_press_event,
  output logic                       out_short_event,
  output logic                       out_long_event,
  output logic                       out_release_event,
  output logic                       out_stable_level,
  input  wire  logic                 cfg_valid,
  output logic                       cfg_ready,
  input  wire  logic [CFG_IDX_W-1:0] cfg_index,
  input  wire  logic [CFG_W-1:0]     cfg_data
);

  cfg_t                   cfg_r;
  logic                   s1_valid_r;
  logic                   s1_pin_r;
  logic                   out_valid_r;
  evt_t                   out_r;
  logic                   raw_seen_r;
  logic                   settling_r;
  logic [TIMER_WIDTH-1:0] settle_cnt_r;
  logic                   debounced_r;
  logic                   hold_armed_r;
  logic [TIMER_WIDTH-1:0] hold_cnt_r;

  logic                   raw_seen_nxt;
  logic                   settling_nxt;
  logic [TIMER_WIDTH-1:0] settle_cnt_nxt;
  logic                   debounced_nxt;
  logic                   hold_armed_nxt;
  logic [TIMER_WIDTH-1:0] hold_cnt_nxt;
  evt_t                   evt;
  logic                   advance;
  logic                   in_fire;
  logic                   step;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign in_fire   = in_valid && in_ready;
  assign step      = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce  <= DEBOUNCE_RST;
      cfg_r.short_max <= SHORT_MAX_RST;
      cfg_r.long_lim  <= LONG_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEBOUNCE:  cfg_r.debounce  <= cfg_data;
        REG_SHORT_MAX: cfg_r.short_max <= cfg_data;
        REG_LONG:      cfg_r.long_lim  <= cfg_data;
        default: ;
      endcase
    end
  end

  bdpc_step #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_step (
    .pin            (s1_pin_r),
    .cfg            (cfg_r),
    .raw_seen       (raw_seen_r),
    .settling       (settling_r),
    .settle_cnt     (settle_cnt_r),
    .debounced      (debounced_r),
    .hold_armed     (hold_armed_r),
    .hold_cnt       (hold_cnt_r),
    .raw_seen_nxt   (raw_seen_nxt),
    .settling_nxt   (settling_nxt),
    .settle_cnt_nxt (settle_cnt_nxt),
    .debounced_nxt  (debounced_nxt),
    .hold_armed_nxt (hold_armed_nxt),
    .hold_cnt_nxt   (hold_cnt_nxt),
    .evt            (evt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      raw_seen_r   <= 1'b1;
      settling_r   <= 1'b0;
      settle_cnt_r <= '0;
      debounced_r  <= 1'b1;
      hold_armed_r <= 1'b0;
      hold_cnt_r   <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (step) begin
        s1_valid_r <= 1'b0;
      end
      if (step) begin
        out_valid_r  <= 1'b1;
        raw_seen_r   <= raw_seen_nxt;
        settling_r   <= settling_nxt;
        settle_cnt_r <= settle_cnt_nxt;
        debounced_r  <= debounced_nxt;
        hold_armed_r <= hold_armed_nxt;
        hold_cnt_r   <= hold_cnt_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pin_r <= in_pin_level;
    end
    if (step) begin
      out_r <= evt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_press_event   = out_r.press;
  assign out_short_event   = out_r.shrt;
  assign out_long_event    = out_r.lng;
  assign out_release_event = out_r.rel;
  assign out_stable_level  = out_r.level;

`ifndef SYNTHESIS
  a_press_rel_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_press_event && out_release_event))
    else $error("press and release in one word");

  a_short_needs_rel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_short_event) |-> out_release_event)
    else $error("short press without release");

  a_level_tracks_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_press_event || out_release_event))
      |-> (out_stable_level == out_release_event))
    else $error("debounced level disagrees with edge event");

  a_step_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> ($stable(debounced_r) && $stable(hold_cnt_r)))
    else $error("state moved without a step");
`endif

endmodule

`default_nettype wire

>>> dv/button_debounce_press_classifier_core_tb.sv
// testbench for the button debouncer and press classifier, checked tick by tick against a predictor
`default_nettype none

module button_debounce_press_classifier_core_tb
  import bdpc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TMR_W = 16;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [TMR_W-1:0] TIMER_TOP = '1;

  localparam evt_t QUIET_UP      = '{press: 1'b0, shrt: 1'b0, lng: 1'b0, rel: 1'b0, level: 1'b1};
  localparam evt_t PRESS_LONG    = '{press: 1'b1, shrt: 1'b0, lng: 1'b1, rel: 1'b0, level: 1'b0};
  localparam evt_t RELEASE_SHORT = '{press: 1'b0, shrt: 1'b1, lng: 1'b0, rel: 1'b1, level: 1'b1};
  localparam evt_t RELEASE_ONLY  = '{press: 1'b0, shrt: 1'b0, lng: 1'b0, rel: 1'b1, level: 1'b1};

  typedef enum logic {ROW_PIN, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY} rx_mode_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      data;
    logic                  pin;
    int                    reps;
    bit                    typed;
    evt_t                  want;
  } row_t;

  localparam int PLAN_ROWS = 24;

  // rows marked typed carry a result that is obvious from the row itself
  row_t plan [PLAN_ROWS] = '{
    '{ROW_PIN, REG_DEBOUNCE,  16'd0,     1'b1, 1,     1'b1, QUIET_UP},
    '{ROW_PIN, REG_DEBOUNCE,  16'd0,     1'b0, 1,     1'b1, QUIET_UP},
    '{ROW_PIN, REG_DEBOUNCE,  16'd0,     1'b0, 15,    1'b0, QUIET_UP},
    '{ROW_PIN, REG_DEBOUNCE,  16'd0,     1'b1, 16,    1'b0, QUIET_UP},
    '{ROW_CFG, REG_DEBOUNCE,  16'd0,     1'b0, 0,     1'b0, QUIET_UP},
    '{ROW_CFG, REG_SHORT_MAX, 16'd3,     1'b0, 0,     1'b0, QUIET_UP},
    '{ROW_CFG, REG_LONG,      16'd0,     1'b0, 0,     1'b0, QUIET_UP},
    '{ROW_PIN, REG_DEBOUNCE,  16'd0,     1'b0, 1,     1'b1, PRESS_LONG},
    '{ROW_PIN, REG_DEBOUNCE,  16'd0,     1'b1, 1,     1'b1, RELEASE_SHORT},
    '{ROW_CFG, REG_LONG,      16'd5,     1'b0, 0,     1'b0, QUIET_UP},
    '{ROW_CFG, REG_DEBOUNCE,  16'd2,     1'b0, 0,     1'b0, QUIET_UP},
    '{ROW_PIN, REG_DEBOUNCE,  16'd0,     1'b0, 1,     1'b0, QUIET_UP},
    '{ROW_PIN, REG_DEBOUNCE,  16'd0,     1'b1, 5,     1'b0, QUIET_UP},
    '{ROW_PIN, REG_DEBOUNCE,  16'd0,     1'b0, 8,     1'b0, QUIET_UP},
    '{ROW_PIN, REG_DEBOUNCE,  16'd0,     1'b1, 3,     1'b0, QUIET_UP},
    '{ROW_CFG, REG_UNUSED,    16'hFFFF,  1'b0, 0,     1'b0, QUIET_UP},
    '{ROW_CFG, REG_DEBOUNCE,  16'hFFFF,  1'b0, 0,     1'b0, QUIET_UP},
    '{ROW_PIN, REG_DEBOUNCE,  16'd0,     1'b0, 6,     1'b0, QUIET_UP},
    '{ROW_PIN, REG_DEBOUNCE,  16'd0,     1'b1, 2,     1'b0, QUIET_UP},
    '{ROW_CFG, REG_DEBOUNCE,  16'd0,     1'b0, 0,     1'b0, QUIET_UP},
    '{ROW_CFG, REG_SHORT_MAX, 16'd100,   1'b0, 0,     1'b0, QUIET_UP},
    '{ROW_CFG, REG_LONG,      16'hFFFF,  1'b0, 0,     1'b0, QUIET_UP},
    // hold past the short limit with the long limit out of reach
    '{ROW_PIN, REG_DEBOUNCE,  16'd0,     1'b0, 200,   1'b0, QUIET_UP},
    '{ROW_PIN, REG_DEBOUNCE,  16'd0,     1'b1, 1,     1'b1, RELEASE_ONLY}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_pin_level = 1'b1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_press_event;
  logic out_short_event;
  logic out_long_event;
  logic out_release_event;
  logic out_stable_level;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // predictor copy of the block state and its registers
  logic pin_seen = 1'b1;
  logic settle_on = 1'b0;
  logic [TMR_W-1:0] settle_cnt = '0;
  logic deb_level = 1'b1;
  logic prev_level = 1'b1;
  logic hold_on = 1'b0;
  logic [TMR_W-1:0] hold_cnt = '0;
  logic [CFG_W-1:0] deb_lim = DEBOUNCE_RST;
  logic [CFG_W-1:0] short_lim = SHORT_MAX_RST;
  logic [CFG_W-1:0] long_lim = LONG_RST;

  evt_t pending_events [$];
  int fail_count = 0;
  int items_sent = 0;
  int burst_left = 0;
  int unsigned cycle_count = 0;

  bit backlog_req = 1'b0;
  bit backlog_done = 1'b0;
  int stall_left = 0;
  int run_left = 0;
  rx_mode_e rx_mode = RX_OPEN;

  button_debounce_press_classifier_core #(
    .TIMER_WIDTH(TMR_W)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pin_level     (in_pin_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_press_event  (out_press_event),
    .out_short_event  (out_short_event),
    .out_long_event   (out_long_event),
    .out_release_event(out_release_event),
    .out_stable_level (out_stable_level),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5ns clk = ~clk;

  function automatic logic [TMR_W-1:0] sat_up(logic [TMR_W-1:0] v);
    return (v == TIMER_TOP) ? v : v + 1'b1;
  endfunction

  function automatic evt_t classify_tick(logic pin);
    evt_t r;
    r = '0;
    hold_cnt = sat_up(hold_cnt);
    if (pin != pin_seen) begin
      pin_seen = pin;
      settle_on = 1'b1;
      settle_cnt = '0;
    end else if (settle_on) begin
      settle_cnt = sat_up(settle_cnt);
    end
    if (settle_on && settle_cnt >= deb_lim) begin
      deb_level = pin_seen;
      settle_on = 1'b0;
    end
    if (deb_level != prev_level) begin
      if (!deb_level) begin
        hold_on = 1'b1;
        r.press = 1'b1;
        hold_cnt = '0;
      end else begin
        r.shrt = (hold_cnt <= short_lim);
        r.rel = 1'b1;
        hold_on = 1'b0;
      end
      prev_level = deb_level;
    end
    // long press fires once per hold
    if (hold_on && hold_cnt >= long_lim) begin
      r.lng = 1'b1;
      hold_on = 1'b0;
    end
    r.level = deb_level;
    return r;
  endfunction

  task automatic push_sample(input logic pin, input bit typed = 1'b0, input evt_t want = '0);
    evt_t predicted;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_pin_level <= pin;
    do @(posedge clk); while (!in_ready);
    predicted = classify_tick(pin);
    pending_events.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic send_run(input logic pin, input int n);
    repeat (n) push_sample(pin);
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    drain_all();
    // result register and input register may still be settling
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DEBOUNCE:  deb_lim = data;
      REG_SHORT_MAX: short_lim = data;
      REG_LONG:      long_lim = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // contact bounce: runs no longer than the debounce limit, but at least one sample each
  task automatic chatter(input logic level);
    int n;
    int w;
    n = $urandom_range(0, 3);
    w = (deb_lim > 1) ? int'(deb_lim) : 1;
    repeat (n) begin
      send_run(level, $urandom_range(1, w));
      send_run(~level, $urandom_range(1, w));
    end
  endtask

  task automatic press_release();
    int hold;
    case ($urandom_range(0, 2))
      0:       hold = int'(short_lim) + int'($urandom_range(0, 8)) - 4;
      1:       hold = int'(long_lim) + int'($urandom_range(0, 8)) - 4;
      default: hold = $urandom_range(0, 50);
    endcase
    if (hold < 1) hold = 1;
    if (hold > 200) hold = 200;
    chatter(1'b0);
    send_run(1'b0, int'(deb_lim) + hold);
    chatter(1'b1);
    send_run(1'b1, int'(deb_lim) + int'($urandom_range(1, 10)));
  endtask

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, actual %0b", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    evt_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        $error("out word with no expected word pending");
        fail_count++;
      end else begin
        want = pending_events.pop_front();
        check_field("press_event", want.press, out_press_event);
        check_field("short_event", want.shrt, out_short_event);
        check_field("long_event", want.lng, out_long_event);
        check_field("release_event", want.rel, out_release_event);
        check_field("stable_level", want.level, out_stable_level);
      end
    end
  end

  // receiver stalls in runs of its own; one long hold-off on request
  always @(posedge clk) begin
    if (backlog_req && !backlog_done) begin
      backlog_done = 1'b1;
      stall_left = 60;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      if (run_left == 0) begin
        run_left = $urandom_range(1, 30);
        rx_mode = rx_mode_e'($urandom_range(0, 2));
      end
      run_left--;
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
        default:   out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [CFG_W-1:0] d;
    logic [CFG_W-1:0] s;
    logic [CFG_W-1:0] l;
    int stop_at;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        repeat (plan[i].reps) push_sample(plan[i].pin, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin
          d = '0;
          s = '0;
          l = '0;
        end
        1: begin
          d = '0;
          s = TIMER_TOP;
          l = TIMER_TOP;
        end
        default: begin
          d = CFG_W'($urandom_range(0, 6));
          s = CFG_W'($urandom_range(0, 20));
          l = CFG_W'($urandom_range(0, 40));
        end
      endcase
      write_reg(REG_DEBOUNCE, d);
      write_reg(REG_SHORT_MAX, s);
      write_reg(REG_LONG, l);
      if (ph == 2) backlog_req = 1'b1;
      stop_at = items_sent + 120;
      while (items_sent < stop_at) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 10)) push_sample(1'($urandom_range(0, 1)));
        end else begin
          press_release();
        end
        if ($urandom_range(0, 30) == 0) drain_all();
      end
    end

    drain_all();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
